// ===== hdl/dsht_pkg.sv =====
package dsht_pkg;

    localparam int MaxEntries = 256;
    localparam int SlotW = 8;
    localparam int SizeW = 9;
    localparam int KeyW = 50;
    localparam int EntryW = 1 + KeyW + 32 + 32 + 8 + 8 + 24;
    localparam logic [31:0] FnvBasis = 32'd2166136261;
    localparam logic [31:0] FnvPrime = 32'd16777619;
    localparam logic [7:0] AuthUnknown = 8'd255;
    localparam logic [8:0] SmallMax = 9'd511;
    localparam logic [SizeW-1:0] SizeMax = 9'd256;

    typedef enum logic [1:0] {
        ST_UPDATED = 2'd0,
        ST_INSERTED = 2'd1,
        ST_FULL = 2'd2
    } status_t;

    typedef enum logic [0:0] {
        CFG_TABLE_SIZE = 1'b0,
        CFG_NOTABLE_MASK = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic [47:0] mac_address;
        logic radio_mode;
        logic random_flag;
        logic [31:0] hint_bits;
        logic signed [7:0] signal_level;
        logic [7:0] radio_channel;
        logic [7:0] auth_kind;
        logic [7:0] pairwise_cipher;
        logic [7:0] group_cipher;
    } sighting_t;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] slot;
        logic [31:0] entry_hits;
        logic [31:0] entry_hints;
        logic signed [7:0] entry_rssi;
        logic [7:0] entry_channel;
        logic [23:0] entry_security;
        logic [8:0] wifi_entries;
        logic [8:0] ble_entries;
        logic [8:0] notable_entries;
        logic [31:0] overflow_count;
        logic [63:0] total_sightings;
    } result_t;

    typedef struct packed {
        logic valid;
        logic [KeyW-1:0] key;
        logic [31:0] hits;
        logic [31:0] hints;
        logic [7:0] rssi;
        logic [7:0] channel;
        logic [23:0] security;
    } entry_t;

    typedef struct packed {
        sighting_t item;
        logic [31:0] hash;
        logic zero_size;
    } job_t;

    typedef enum logic [2:0] {
        FE_IDLE,
        FE_HASH,
        FE_PUSH
    } fe_state_t;

    typedef enum logic [2:0] {
        BE_IDLE,
        BE_MOD,
        BE_READ,
        BE_WAIT,
        BE_CHECK,
        BE_OUT
    } be_state_t;

endpackage

// ===== hdl/dsht_ram.sv =====
module dsht_ram #(
    parameter int Width = 8,
    parameter int Depth = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== hdl/dsht_front.sv =====
module dsht_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  dsht_pkg::sighting_t in_data,
    input  logic [8:0]          size,
    output logic                job_valid,
    input  logic                job_stall,
    output dsht_pkg::job_t      job
);
    import dsht_pkg::*;

    fe_state_t state_reg, state_next;
    sighting_t item_reg, item_next;
    logic [31:0] hash_reg, hash_next;
    logic [3:0] step_reg, step_next;
    logic [31:0] feed;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FE_IDLE;
            step_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        hash_reg <= hash_next;
    end

    always_comb
    begin
        unique case (step_reg)
            4'd0: feed = {24'd0, item_reg.mac_address[47:40]};
            4'd1: feed = {24'd0, item_reg.mac_address[39:32]};
            4'd2: feed = {24'd0, item_reg.mac_address[31:24]};
            4'd3: feed = {24'd0, item_reg.mac_address[23:16]};
            4'd4: feed = {24'd0, item_reg.mac_address[15:8]};
            4'd5: feed = {24'd0, item_reg.mac_address[7:0]};
            4'd6: feed = {31'd0, item_reg.radio_mode};
            default: feed = {31'd0, item_reg.random_flag};
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        item_next = item_reg;
        hash_next = hash_reg;
        step_next = step_reg;
        in_stall = 1'b1;
        job_valid = 1'b0;
        job.item = item_reg;
        job.hash = hash_reg;
        job.zero_size = (size == '0);
        unique case (state_reg)
            FE_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    item_next = in_data;
                    hash_next = FnvBasis;
                    step_next = '0;
                    state_next = FE_HASH;
                end
            end
            FE_HASH:
            begin
                hash_next = (hash_reg ^ feed) * FnvPrime;
                step_next = step_reg + 4'd1;
                if (step_reg == 4'd7)
                begin
                    state_next = FE_PUSH;
                end
            end
            FE_PUSH:
            begin
                job_valid = 1'b1;
                if (!job_stall)
                begin
                    state_next = FE_IDLE;
                end
            end
            default: state_next = FE_IDLE;
        endcase
    end
endmodule

// ===== hdl/dsht_back.sv =====
module dsht_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              job_valid,
    output logic              job_stall,
    input  dsht_pkg::job_t    job,
    input  logic [8:0]        size,
    input  logic [31:0]       notable_mask,
    output logic              out_valid,
    input  logic              out_stall,
    output dsht_pkg::result_t out_data
);
    import dsht_pkg::*;

    be_state_t state_reg, state_next;
    job_t job_reg, job_next;
    logic [31:0] rem_reg, rem_next;
    logic [5:0] bit_reg, bit_next;
    logic [SlotW-1:0] idx_reg, idx_next;
    logic [SizeW-1:0] n_reg, n_next;
    logic [SizeW-1:0] eff_size;
    logic [SlotW:0] clr_reg, clr_next;
    logic clearing;
    result_t res_reg, res_next;
    logic [63:0] sight_reg, sight_next;
    logic [8:0] wifi_reg, wifi_next, ble_reg, ble_next, notable_reg, notable_next;
    logic [31:0] over_reg, over_next;
    logic we;
    logic [SlotW-1:0] waddr;
    entry_t wdata, rdata;
    logic [KeyW-1:0] key;
    logic [32:0] trial;
    logic [SizeW:0] idx_inc;
    logic [23:0] sec_in;

    dsht_ram #(.Width(EntryW), .Depth(MaxEntries)) u_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(idx_reg), .rdata(rdata)
    );

    assign clearing = !clr_reg[SlotW];
    assign eff_size = (size > SizeMax) ? SizeMax : size;
    assign key = {job_reg.item.random_flag, job_reg.item.radio_mode,
                  job_reg.item.mac_address};
    assign trial = {rem_reg, job_reg.hash[bit_reg[4:0]]} - {24'd0, eff_size};
    assign idx_inc = {1'b0, idx_reg} + 10'd1;
    assign sec_in = {job_reg.item.auth_kind, job_reg.item.pairwise_cipher,
                     job_reg.item.group_cipher};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BE_IDLE;
            clr_reg <= '0;
            sight_reg <= '0;
            wifi_reg <= '0;
            ble_reg <= '0;
            notable_reg <= '0;
            over_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg <= clr_next;
            sight_reg <= sight_next;
            wifi_reg <= wifi_next;
            ble_reg <= ble_next;
            notable_reg <= notable_next;
            over_reg <= over_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
        rem_reg <= rem_next;
        bit_reg <= bit_next;
        idx_reg <= idx_next;
        n_reg <= n_next;
        res_reg <= res_next;
    end

    always_comb
    begin
        state_next = state_reg;
        job_next = job_reg;
        rem_next = rem_reg;
        bit_next = bit_reg;
        idx_next = idx_reg;
        n_next = n_reg;
        res_next = res_reg;
        sight_next = sight_reg;
        wifi_next = wifi_reg;
        ble_next = ble_reg;
        notable_next = notable_reg;
        over_next = over_reg;
        clr_next = clr_reg;
        we = 1'b0;
        waddr = idx_reg;
        wdata = rdata;
        job_stall = 1'b1;
        out_valid = 1'b0;
        out_data = res_reg;
        if (clearing)
        begin
            we = 1'b1;
            waddr = clr_reg[SlotW-1:0];
            wdata = '0;
            clr_next = clr_reg + 1'b1;
        end
        unique case (state_reg)
            BE_IDLE:
            begin
                job_stall = clearing;
                if (job_valid && !clearing)
                begin
                    job_next = job;
                    rem_next = '0;
                    bit_next = 6'd31;
                    n_next = '0;
                    res_next = '0;
                    res_next.status = ST_FULL;
                    if (job.zero_size)
                    begin
                        state_next = BE_OUT;
                    end
                    else
                    begin
                        if (sight_reg != '1)
                        begin
                            sight_next = sight_reg + 64'd1;
                        end
                        state_next = BE_MOD;
                    end
                end
            end
            BE_MOD:
            begin
                if (!trial[32])
                begin
                    rem_next = trial[31:0];
                end
                else
                begin
                    rem_next = {rem_reg[30:0], job_reg.hash[bit_reg[4:0]]};
                end
                bit_next = bit_reg - 6'd1;
                if (bit_reg == 6'd0)
                begin
                    state_next = BE_READ;
                end
            end
            BE_READ:
            begin
                idx_next = rem_reg[SlotW-1:0];
                state_next = BE_WAIT;
            end
            BE_WAIT:
            begin
                state_next = BE_CHECK;
            end
            BE_CHECK:
            begin
                if (!rdata.valid)
                begin
                    we = 1'b1;
                    wdata.valid = 1'b1;
                    wdata.key = key;
                    wdata.hits = 32'd1;
                    wdata.hints = job_reg.item.hint_bits;
                    wdata.rssi = job_reg.item.signal_level;
                    wdata.channel = job_reg.item.radio_channel;
                    wdata.security = sec_in;
                    if (!job_reg.item.radio_mode)
                    begin
                        if (wifi_reg != SmallMax) wifi_next = wifi_reg + 9'd1;
                    end
                    else if (ble_reg != SmallMax)
                    begin
                        ble_next = ble_reg + 9'd1;
                    end
                    if (((job_reg.item.hint_bits & notable_mask) != '0)
                        && notable_reg != SmallMax)
                    begin
                        notable_next = notable_reg + 9'd1;
                    end
                    res_next.status = ST_INSERTED;
                end
                else if (rdata.key == key)
                begin
                    we = 1'b1;
                    wdata.rssi = job_reg.item.signal_level;
                    if (job_reg.item.radio_channel != '0)
                        wdata.channel = job_reg.item.radio_channel;
                    if (job_reg.item.auth_kind != AuthUnknown)
                        wdata.security = sec_in;
                    if (((rdata.hints & notable_mask) == '0)
                        && ((job_reg.item.hint_bits & notable_mask) != '0)
                        && notable_reg != SmallMax)
                    begin
                        notable_next = notable_reg + 9'd1;
                    end
                    wdata.hints = rdata.hints | job_reg.item.hint_bits;
                    if (rdata.hits != '1) wdata.hits = rdata.hits + 32'd1;
                    res_next.status = ST_UPDATED;
                end
                if (!rdata.valid || rdata.key == key)
                begin
                    res_next.slot = idx_reg;
                    res_next.entry_hits = wdata.hits;
                    res_next.entry_hints = wdata.hints;
                    res_next.entry_rssi = wdata.rssi;
                    res_next.entry_channel = wdata.channel;
                    res_next.entry_security = wdata.security;
                    state_next = BE_OUT;
                end
                else if (n_reg + 9'd1 >= eff_size)
                begin
                    if (over_reg != '1) over_next = over_reg + 32'd1;
                    state_next = BE_OUT;
                end
                else
                begin
                    n_next = n_reg + 9'd1;
                    idx_next = (idx_inc >= {1'b0, eff_size}) ? '0 : idx_inc[SlotW-1:0];
                    state_next = BE_WAIT;
                end
            end
            BE_OUT:
            begin
                out_valid = 1'b1;
                out_data.wifi_entries = wifi_reg;
                out_data.ble_entries = ble_reg;
                out_data.notable_entries = notable_reg;
                out_data.overflow_count = over_reg;
                out_data.total_sightings = sight_reg;
                if (!out_stall)
                begin
                    state_next = BE_IDLE;
                end
            end
            default: state_next = BE_IDLE;
        endcase
    end
endmodule

// ===== hdl/device_sighting_hash_table_unit.sv =====
// Channel  Handshake       Payload
// in       valid / stall   sighting_t
// out      valid / stall   result_t
// cfg      valid / ready   cfg_index, cfg_data
// An item passes through hashing, a handoff to the back end, a bit-serial modulo, an address
// step, then a read wait and a check per probed slot, and an output state held while out_stall is high.
// The registered read of the table memory puts a wait state before each slot check.
// After reset a clearing pass zeroes all 256 table entries before the back end takes its first request.
// The hash front end takes the next request while the back end probes.
module device_sighting_hash_table_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  dsht_pkg::sighting_t in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output dsht_pkg::result_t   out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_index,
    input  logic [31:0]         cfg_data
);
    import dsht_pkg::*;

    logic [8:0] size_reg;
    logic [31:0] mask_reg;
    logic job_valid, job_stall;
    job_t job;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= SizeMax;
            mask_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_TABLE_SIZE: size_reg <= cfg_data[8:0];
                CFG_NOTABLE_MASK: mask_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    dsht_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .in_data(in_data), .size(size_reg), .job_valid(job_valid),
        .job_stall(job_stall), .job(job)
    );

    dsht_back u_back (
        .clk(clk), .rst_n(rst_n), .job_valid(job_valid), .job_stall(job_stall),
        .job(job), .size(size_reg), .notable_mask(mask_reg),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
    );
endmodule
